>>> src/cia_pkg.sv
// package for the timer, time-of-day and interrupt unit
// payload structs and register codes; no dependencies
package cia_pkg;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_TOD   = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		REG_PRA   = 4'd0,
		REG_PRB   = 4'd1,
		REG_DDRA  = 4'd2,
		REG_DDRB  = 4'd3,
		REG_TALO  = 4'd4,
		REG_TAHI  = 4'd5,
		REG_TBLO  = 4'd6,
		REG_TBHI  = 4'd7,
		REG_TODLO = 4'd8,
		REG_TODMID = 4'd9,
		REG_TODHI = 4'd10,
		REG_UNUSED = 4'd11,
		REG_SDR   = 4'd12,
		REG_ICR   = 4'd13,
		REG_CRA   = 4'd14,
		REG_CRB   = 4'd15
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [3:0] reg_index;
		logic [7:0] wdata;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic       irq_active;
	} out_beat_t;

	localparam logic [7:0] CR_START    = 8'h01;
	localparam logic [7:0] CR_ONESHOT  = 8'h08;
	localparam logic [7:0] CR_LOAD     = 8'h10;
	localparam logic [7:0] CR_ATTACH   = 8'h41;
	localparam logic [7:0] CR_ALARM    = 8'h80;
	localparam logic [7:0] ICR_SET     = 8'h80;
	localparam logic [4:0] ICR_MASK    = 5'h1f;
	localparam logic [4:0] IRQ_TA      = 5'h01;
	localparam logic [4:0] IRQ_TB      = 5'h02;
	localparam logic [4:0] IRQ_ALRM    = 5'h04;

	function automatic logic [15:0] load_value(input logic [15:0] latch);
		load_value = (latch == 16'd0) ? 16'd1 : latch;
	endfunction

endpackage

>>> src/cia_timer_tod_interrupt_unit.sv
// Takes one register access or tick per cycle (registered input beat, one
// pass of update logic, registered result) unless stalled. Depends on cia_pkg.
//
// The unit accepts one beat every clock: an input register holds the beat,
// the state update and result are computed in one pass, and the result lands
// in an output register once that register is empty or being taken.
// Throughput is one beat per cycle while the result side keeps up, and a
// stalled result holds the input register and drops in_ready.
module cia_timer_tod_interrupt_unit import cia_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);

	logic     v_s1;
	in_beat_t b_s1;
	logic     adv;
	logic     unit_q;

	logic [15:0] ta_q, tb_q, tal_q, tbl_q;
	logic [7:0]  cra_q, crb_q, irq_q;
	logic [4:0]  msk_q;
	logic [23:0] tod_q, alm_q, rh_q, ws_q;
	logic        rhing_q, whing_q;
	logic [7:0]  pa_q, pb_q, ddrb_q, sdr_q;

	logic [15:0] ta_n, tb_n, tal_n, tbl_n;
	logic [7:0]  cra_n, crb_n, irq_n, rd;
	logic [4:0]  msk_n;
	logic [23:0] tod_n, alm_n, rh_n, ws_n;
	logic        rhing_n, whing_n;
	logic [7:0]  pa_n, pb_n, ddrb_n, sdr_n;

	// result stage moves when empty or taken
	assign adv      = !out_valid || out_ready;
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			unit_q <= 1'b0;
		end else begin
			if (cfg_we) unit_q <= cfg_wdata;
			if (in_ready) v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) b_s1 <= in_data;
	end

	function automatic logic alarm_hit(input logic [23:0] t, input logic [23:0] a);
		logic [23:0] tm;
		tm = t - 24'd1;
		alarm_hit = (t == a) || ((t[11:0] == 12'd0) && ({tm[23:12], 12'd0} == a));
	endfunction

	always_comb begin
		logic [4:0] raise;
		logic [15:0] dec;
		logic       ua, bcnt;
		ta_n = ta_q; tb_n = tb_q; tal_n = tal_q; tbl_n = tbl_q;
		cra_n = cra_q; crb_n = crb_q; irq_n = irq_q; msk_n = msk_q;
		tod_n = tod_q; alm_n = alm_q; rh_n = rh_q; ws_n = ws_q;
		rhing_n = rhing_q; whing_n = whing_q;
		pa_n = pa_q; pb_n = pb_q; ddrb_n = ddrb_q; sdr_n = sdr_q;
		rd = 8'd0; raise = 5'd0; ua = 1'b0; bcnt = 1'b0; dec = 16'd0;
		case (cmd_t'(b_s1.cmd))
			CMD_READ: begin
				unique case (reg_idx_t'(b_s1.reg_index))
					REG_PRA:  rd = pa_q;
					REG_PRB:  rd = pb_q;
					REG_DDRA: rd = unit_q ? 8'hff : 8'h03;
					REG_DDRB: rd = unit_q ? 8'hff : ddrb_q;
					REG_TALO: rd = ta_q[7:0];
					REG_TAHI: rd = ta_q[15:8];
					REG_TBLO: rd = tb_q[7:0];
					REG_TBHI: rd = tb_q[15:8];
					REG_TODLO: begin
						rd = rhing_q ? rh_q[7:0] : tod_q[7:0];
						rhing_n = 1'b0;
					end
					REG_TODMID: rd = rhing_q ? rh_q[15:8] : tod_q[15:8];
					REG_TODHI: begin
						rd = tod_q[23:16];
						rhing_n = 1'b1;
						rh_n = tod_q;
					end
					REG_SDR: begin
						rd = sdr_q;
					end
					REG_ICR: begin
						rd = irq_q;
						irq_n = 8'd0;
					end
					REG_CRA: rd = cra_q;
					REG_CRB: rd = crb_q;
					default: rd = 8'hff;
				endcase
			end
			CMD_WRITE: begin
				unique case (reg_idx_t'(b_s1.reg_index))
					REG_PRA: pa_n = b_s1.wdata;
					REG_PRB: pb_n = b_s1.wdata;
					REG_DDRB: if (!unit_q) ddrb_n = b_s1.wdata;
					REG_TALO: tal_n[7:0] = b_s1.wdata;
					REG_TAHI: begin
						tal_n[15:8] = b_s1.wdata;
						if (!cra_q[0] || cra_q[3]) ta_n = load_value(tal_n);
						if (cra_q[3]) cra_n[0] = 1'b1;
					end
					REG_TBLO: tbl_n[7:0] = b_s1.wdata;
					REG_TBHI: begin
						tbl_n[15:8] = b_s1.wdata;
						if (!crb_q[0] || crb_q[3]) tb_n = load_value(tbl_n);
						if (crb_q[3]) crb_n[0] = 1'b1;
					end
					REG_TODLO: begin
						if (crb_q[7]) alm_n[7:0] = b_s1.wdata;
						else begin
							whing_n = 1'b0;
							ws_n[7:0] = b_s1.wdata;
							tod_n = ws_n;
						end
						if (!whing_n && alarm_hit(tod_n, alm_n)) raise = IRQ_ALRM;
					end
					REG_TODMID: begin
						if (crb_q[7]) begin
							alm_n[15:8] = b_s1.wdata;
							if (!whing_q && alarm_hit(tod_q, alm_n)) raise = IRQ_ALRM;
						end else begin
							whing_n = 1'b1;
							ws_n[15:8] = b_s1.wdata;
						end
					end
					REG_TODHI: begin
						if (crb_q[7]) begin
							alm_n[23:16] = b_s1.wdata;
							if (!whing_q && alarm_hit(tod_q, alm_n)) raise = IRQ_ALRM;
						end else begin
							whing_n = 1'b1;
							ws_n[23:16] = b_s1.wdata;
						end
					end
					REG_SDR: sdr_n = b_s1.wdata;
					REG_ICR: begin
						if (b_s1.wdata[7]) msk_n = msk_q | b_s1.wdata[4:0];
						else msk_n = msk_q & ~b_s1.wdata[4:0];
					end
					REG_CRA: begin
						if (b_s1.wdata[4]) ta_n = load_value(tal_q);
						cra_n = b_s1.wdata & ~CR_LOAD;
					end
					REG_CRB: begin
						if (b_s1.wdata[4]) tb_n = load_value(tbl_q);
						crb_n = b_s1.wdata & ~CR_LOAD;
					end
					default: ;
				endcase
			end
			CMD_TICK: begin
				if (cra_q[0]) begin
					ta_n = ta_q - 16'd1;
					if (ta_n == 16'd0) begin
						ua = 1'b1;
						ta_n = load_value(tal_q);
						if (cra_q[3]) cra_n[0] = 1'b0;
						raise = raise | IRQ_TA;
					end
				end
				bcnt = ((crb_q & CR_ATTACH) == CR_START) ||
					(ua && ((crb_q & CR_ATTACH) == CR_ATTACH));
				if (bcnt) begin
					dec = tb_q - 16'd1;
					tb_n = dec;
					if (dec == 16'd0) begin
						tb_n = load_value(tbl_q);
						if (crb_q[3]) crb_n[0] = 1'b0;
						raise = raise | IRQ_TB;
					end
				end
			end
			default: begin
				if (!whing_q) begin
					tod_n = tod_q + 24'd1;
					if (alarm_hit(tod_n, alm_q)) raise = IRQ_ALRM;
				end
			end
		endcase
		irq_n[4:0] = irq_n[4:0] | raise;
		if ((irq_n[4:0] & msk_n) != 5'd0) irq_n[7] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ta_q <= 16'hffff; tb_q <= 16'hffff; tal_q <= 16'hffff; tbl_q <= 16'hffff;
			cra_q <= 8'd0; crb_q <= 8'd0; irq_q <= 8'd0; msk_q <= 5'd0;
			tod_q <= 24'd0; alm_q <= 24'd0; rh_q <= 24'd0; ws_q <= 24'd0;
			rhing_q <= 1'b0; whing_q <= 1'b1;
			pa_q <= 8'hff; pb_q <= 8'd0; ddrb_q <= 8'd0; sdr_q <= 8'd0;
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s1;
			if (v_s1) begin
				ta_q <= ta_n; tb_q <= tb_n; tal_q <= tal_n; tbl_q <= tbl_n;
				cra_q <= cra_n; crb_q <= crb_n; irq_q <= irq_n; msk_q <= msk_n;
				tod_q <= tod_n; alm_q <= alm_n; rh_q <= rh_n; ws_q <= ws_n;
				rhing_q <= rhing_n; whing_q <= whing_n;
				pa_q <= pa_n; pb_q <= pb_n; ddrb_q <= ddrb_n; sdr_q <= sdr_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			out_data.rdata      <= rd;
			out_data.irq_active <= irq_n[7];
		end
	end

`ifndef SYNTHESIS
	a_tod_hold: assert property (@(posedge clk) disable iff (!arst_n)
		whing_q && !(adv && v_s1 && cmd_t'(b_s1.cmd) == CMD_WRITE &&
		reg_idx_t'(b_s1.reg_index) == REG_TODLO) |=> $stable(tod_q))
		else $error("tod moved while held");
	a_summary: assert property (@(posedge clk) disable iff (!arst_n)
		((irq_q[4:0] & msk_q) != 5'd0) && !$past(v_s1 && b_s1.cmd == CMD_READ &&
		b_s1.reg_index == REG_ICR) |-> irq_q[7] || $past(!arst_n))
		else $error("irq summary missing");
	a_ta_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ta_q != 16'd0) else $error("timer a zero");
`endif

endmodule

>>> tb/sv/cia_timer_tod_interrupt_unit_tb.sv
// testbench for the timer, time-of-day and interrupt unit: random and directed
// register accesses and ticks checked beat by beat against a behavioral predictor
// depends on cia_pkg and cia_timer_tod_interrupt_unit
module cia_timer_tod_interrupt_unit_tb;
	import cia_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_beat_t out_data;
	logic      cfg_we;
	logic      cfg_wdata;

	cia_timer_tod_interrupt_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// predictor state
	logic        unit_sel;
	logic [15:0] ta_cnt, tb_cnt, ta_lat, tb_lat;
	logic [7:0]  cra, crb, icr_req;
	logic [4:0]  icr_mask;
	logic [23:0] tod, alarm, tod_hold, tod_stage;
	logic        tod_holding, tod_stopped;
	logic [7:0]  pra, prb, ddrb, sdr;

	in_beat_t  beat_q[$];
	out_beat_t result_q[$];
	int        errors;
	int        cycles;
	bit        quiet_phase;
	bit        hold_send;

	function automatic logic [15:0] reload(input logic [15:0] l);
		return (l == 16'd0) ? 16'd1 : l;
	endfunction

	task automatic irq_refresh();
		if ((icr_req[4:0] & icr_mask) != 5'd0)
			icr_req[7] = 1'b1;
	endtask

	task automatic irq_raise(input logic [4:0] bits);
		icr_req[4:0] = icr_req[4:0] | bits;
		irq_refresh();
	endtask

	task automatic alarm_check();
		logic [23:0] prev;
		prev = tod - 24'd1;
		if (tod_stopped)
			return;
		if (tod == alarm || (tod[11:0] == 12'd0 && (prev & 24'hfff000) == alarm))
			irq_raise(IRQ_ALRM);
	endtask

	task automatic tb_underflow();
		tb_cnt = reload(tb_lat);
		if (crb & CR_ONESHOT)
			crb = crb & ~CR_START;
		irq_raise(IRQ_TB);
	endtask

	task automatic ta_underflow();
		ta_cnt = reload(ta_lat);
		if ((crb & CR_ATTACH) == CR_ATTACH) begin
			tb_cnt = tb_cnt - 16'd1;
			if (tb_cnt == 16'd0)
				tb_underflow();
		end
		if (cra & CR_ONESHOT)
			cra = cra & ~CR_START;
		irq_raise(IRQ_TA);
	endtask

	function automatic logic [7:0] reg_rd(input logic [3:0] r);
		logic [7:0] v;
		v = 8'hff;
		case (reg_idx_t'(r))
			REG_PRA: v = pra;
			REG_PRB: v = prb;
			REG_DDRA: v = unit_sel ? 8'hff : 8'h03;
			REG_DDRB: v = unit_sel ? 8'hff : ddrb;
			REG_TALO: v = ta_cnt[7:0];
			REG_TAHI: v = ta_cnt[15:8];
			REG_TBLO: v = tb_cnt[7:0];
			REG_TBHI: v = tb_cnt[15:8];
			REG_TODLO: begin
				v = tod_holding ? tod_hold[7:0] : tod[7:0];
				tod_holding = 1'b0;
			end
			REG_TODMID: v = tod_holding ? tod_hold[15:8] : tod[15:8];
			REG_TODHI: begin
				tod_holding = 1'b1;
				tod_hold = tod;
				v = tod[23:16];
			end
			REG_SDR: v = sdr;
			REG_ICR: begin
				v = icr_req;
				icr_req = 8'd0;
			end
			REG_CRA: v = cra;
			REG_CRB: v = crb;
			default: v = 8'hff;
		endcase
		return v;
	endfunction

	task automatic reg_wr(input logic [3:0] r, input logic [7:0] d);
		case (reg_idx_t'(r))
			REG_PRA: pra = d;
			REG_PRB: prb = d;
			REG_DDRB: if (!unit_sel) ddrb = d;
			REG_TALO: ta_lat[7:0] = d;
			REG_TAHI: begin
				ta_lat[15:8] = d;
				if (!(cra & CR_START) || (cra & CR_ONESHOT))
					ta_cnt = reload(ta_lat);
				if (cra & CR_ONESHOT)
					cra = cra | CR_START;
			end
			REG_TBLO: tb_lat[7:0] = d;
			REG_TBHI: begin
				tb_lat[15:8] = d;
				if (!(crb & CR_START) || (crb & CR_ONESHOT))
					tb_cnt = reload(tb_lat);
				if (crb & CR_ONESHOT)
					crb = crb | CR_START;
			end
			REG_TODLO: begin
				if (crb & CR_ALARM)
					alarm[7:0] = d;
				else begin
					tod_stopped = 1'b0;
					tod_stage[7:0] = d;
					tod = tod_stage;
				end
				alarm_check();
			end
			REG_TODMID: begin
				if (crb & CR_ALARM) begin
					alarm[15:8] = d;
					alarm_check();
				end else begin
					tod_stopped = 1'b1;
					tod_stage[15:8] = d;
				end
			end
			REG_TODHI: begin
				if (crb & CR_ALARM) begin
					alarm[23:16] = d;
					alarm_check();
				end else begin
					tod_stopped = 1'b1;
					tod_stage[23:16] = d;
				end
			end
			REG_SDR: sdr = d;
			REG_ICR: begin
				if (d & ICR_SET)
					icr_mask = icr_mask | d[4:0];
				else
					icr_mask = icr_mask & ~d[4:0];
				irq_refresh();
			end
			REG_CRA: begin
				if (d & CR_LOAD) begin
					ta_cnt = reload(ta_lat);
					d = d & ~CR_LOAD;
				end
				cra = d;
			end
			REG_CRB: begin
				if (d & CR_LOAD) begin
					tb_cnt = reload(tb_lat);
					d = d & ~CR_LOAD;
				end
				crb = d;
			end
			default: ;
		endcase
	endtask

	task automatic unit_predict(input in_beat_t b);
		out_beat_t o;
		logic run_a, run_b;
		o.rdata = 8'd0;
		case (cmd_t'(b.cmd))
			CMD_READ: o.rdata = reg_rd(b.reg_index);
			CMD_WRITE: reg_wr(b.reg_index, b.wdata);
			CMD_TICK: begin
				run_a = cra[0];
				run_b = (crb & CR_ATTACH) == CR_START;
				if (run_a) begin
					ta_cnt = ta_cnt - 16'd1;
					if (ta_cnt == 16'd0)
						ta_underflow();
				end
				if (run_b) begin
					tb_cnt = tb_cnt - 16'd1;
					if (tb_cnt == 16'd0)
						tb_underflow();
				end
			end
			default: begin
				if (!tod_stopped) begin
					tod = tod + 24'd1;
					alarm_check();
				end
			end
		endcase
		o.irq_active = icr_req[7];
		result_q.push_back(o);
	endtask

	task automatic unit_reset();
		unit_sel = 1'b0;
		ta_cnt = 16'hffff; tb_cnt = 16'hffff; ta_lat = 16'hffff; tb_lat = 16'hffff;
		cra = 8'd0; crb = 8'd0; icr_req = 8'd0; icr_mask = 5'd0;
		tod = 24'd0; alarm = 24'd0; tod_hold = 24'd0; tod_stage = 24'd0;
		tod_holding = 1'b0; tod_stopped = 1'b1;
		pra = 8'hff; prb = 8'd0; ddrb = 8'd0; sdr = 8'd0;
	endtask

	function automatic in_beat_t mk(input cmd_t c, input reg_idx_t r, input logic [7:0] d);
		in_beat_t b;
		b.cmd = c;
		b.reg_index = r;
		b.wdata = d;
		return b;
	endfunction

	function automatic in_beat_t rand_beat();
		in_beat_t b;
		int k;
		k = $urandom_range(0, 99);
		b.reg_index = $urandom_range(0, 15);
		b.wdata = $urandom_range(0, 255);
		if (k < 40)
			b.cmd = CMD_TICK;
		else if (k < 55)
			b.cmd = CMD_TOD;
		else if (k < 78)
			b.cmd = CMD_READ;
		else
			b.cmd = CMD_WRITE;
		// keep timers short so underflows happen often
		if (b.cmd == CMD_WRITE && (b.reg_index == REG_TAHI || b.reg_index == REG_TBHI)
		    && $urandom_range(0, 3) != 0)
			b.wdata = $urandom_range(0, 1);
		return b;
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready)
				unit_predict(in_data);
			if (!(in_valid && !in_ready)) begin
				if (beat_q.size() != 0 && !hold_send &&
				    (quiet_phase || $urandom_range(0, 99) >= 24)) begin
					in_valid <= 1'b1;
					in_data <= beat_q.pop_front();
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else begin
			cycles <= cycles + 1;
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					$display("%0t unexpected beat: actual %h", $time, out_data);
					errors++;
				end else begin
					out_beat_t e;
					e = result_q.pop_front();
					if (e.rdata !== out_data.rdata) begin
						$display("%0t rdata: expected %h actual %h", $time, e.rdata,
							out_data.rdata);
						errors++;
					end
					if (e.irq_active !== out_data.irq_active) begin
						$display("%0t irq_active: expected %b actual %b", $time,
							e.irq_active, out_data.irq_active);
						errors++;
					end
				end
			end
			out_ready <= quiet_phase || $urandom_range(0, 99) >= 24;
		end
	end

	always @(posedge clk) begin
		if (cycles > 400000) begin
			$display("[cia_timer_tod_interrupt_unit] ERROR");
			$finish;
		end
	end

	task automatic drain();
		while (beat_q.size() != 0 || in_valid || result_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_unit(input logic v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		unit_sel = v;
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		quiet_phase = 1'b0;
		hold_send = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		unit_reset();
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		set_unit(1'b0);

		// directed: reset values, timers, one-shot, tod, alarm, interrupts
		for (int r = 0; r < 16; r++)
			beat_q.push_back(mk(CMD_READ, reg_idx_t'(r), 8'h00));
		beat_q.push_back(mk(CMD_WRITE, REG_DDRB, 8'ha5));
		beat_q.push_back(mk(CMD_WRITE, REG_ICR, 8'h9f));
		beat_q.push_back(mk(CMD_WRITE, REG_TALO, 8'h00));
		beat_q.push_back(mk(CMD_WRITE, REG_TAHI, 8'h00));
		beat_q.push_back(mk(CMD_WRITE, REG_CRB, 8'h59));
		beat_q.push_back(mk(CMD_WRITE, REG_CRA, 8'h19));
		beat_q.push_back(mk(CMD_TICK, REG_PRA, 8'h00));
		beat_q.push_back(mk(CMD_WRITE, REG_TODLO, 8'h00));
		beat_q.push_back(mk(CMD_TOD, REG_PRA, 8'h00));
		beat_q.push_back(mk(CMD_READ, REG_ICR, 8'h00));
		beat_q.push_back(mk(CMD_WRITE, REG_ICR, 8'h1f));
		beat_q.push_back(mk(CMD_WRITE, REG_SDR, 8'hff));
		drain();
		set_unit(1'b1);
		beat_q.push_back(mk(CMD_WRITE, REG_DDRB, 8'h5a));
		beat_q.push_back(mk(CMD_READ, REG_DDRA, 8'h00));
		beat_q.push_back(mk(CMD_READ, REG_DDRB, 8'h00));
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			quiet_phase = (ph == 2);
			for (int i = 0; i < 160; i++)
				beat_q.push_back(rand_beat());
			if (ph == 1) begin
				while (beat_q.size() > 80)
					@(posedge clk);
				hold_send = 1'b1;
				while (in_valid || result_q.size() != 0)
					@(posedge clk);
				hold_send = 1'b0;
			end
			drain();
			set_unit(ph[0]);
		end

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("[cia_timer_tod_interrupt_unit] OK");
		else
			$display("[cia_timer_tod_interrupt_unit] ERROR");
		$finish;
	end
endmodule
